### hdl/ffsa_pkg.sv
// Package for the first-fit segment allocator.
// Holds status codes, function codes, the entry widths and layout, and the sequencer state type.
// No dependencies.
package ffsa_pkg;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_NOFIT    = 2'd1;
  localparam logic [1:0] ST_FULL     = 2'd2;
  localparam logic [1:0] ST_NOTFOUND = 2'd3;

  localparam logic FUNC_ALLOC = 1'b0;
  localparam logic FUNC_FREE  = 1'b1;

  localparam int LEN_W = 17;
  localparam int START_W = 16;
  localparam int ENTRY_W = START_W + LEN_W + 1;

  typedef struct packed {
    logic [START_W-1:0] start;
    logic [LEN_W-1:0]   len;
    logic               is_free;
  } entry_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_INIT,
    S_SCAN_RD,
    S_SCAN_CHK,
    S_SHUP_RD,
    S_SHUP_WR,
    S_SPLIT,
    S_FREE_NX,
    S_FREE_NXCHK,
    S_FREE_PV,
    S_FREE_PVCHK,
    S_SHDN_RD,
    S_SHDN_WR,
    S_DONE
  } state_t;

endpackage

### hdl/ffsa_ram.sv
// Generic single-port-write, single-port-read RAM with registered read.
// No dependencies.
module ffsa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

### hdl/first_fit_segment_allocator.sv
// Top level of the first-fit segment allocator.
// Depends on ffsa_pkg and ffsa_ram.
//
// A request is taken with start high while busy is low: func selects
// allocate or free, alloc_size and free_addr carry the operands. One result
// (addr, status) appears for one cycle with done high; it cannot be held off.
// The segment table lives in one RAM of MAX_SEGMENTS entries with registered
// read, walked by a sequencer that reads one entry per S_SCAN_RD/S_SCAN_CHK
// pass. A split moves the entries above the hit entry up by one, and each
// merge on a free moves the entries above the merged one down by one.
// busy drops in the cycle that carries the result, so the next request can
// be taken in that cycle. After reset, and after each write of pool_size
// over the APB port, the table is rebuilt as one free segment; this writes
// only entry 0, as entries at or above the segment count are never read.
// pool_size reads back.
module first_fit_segment_allocator #(
  parameter int MAX_SEGMENTS = 16,
  parameter int POOL_BYTES = 65536
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [1:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        start,
  output logic        busy,
  input  logic        func,
  input  logic [16:0] alloc_size,
  input  logic [15:0] free_addr,
  output logic        done,
  output logic [15:0] addr,
  output logic [1:0]  status
);
  import ffsa_pkg::*;

  localparam int IW = $clog2(MAX_SEGMENTS);
  localparam int CW = $clog2(MAX_SEGMENTS + 1);
  localparam logic [LEN_W-1:0] CAP =
    (POOL_BYTES < 65536) ? LEN_W'(POOL_BYTES) : LEN_W'(65536);
  localparam logic [CW-1:0] MAXC = CW'(MAX_SEGMENTS);

  state_t state, state_next;
  logic [LEN_W-1:0] pool_size;
  logic [CW-1:0] seg_count;
  logic [IW:0] idx;
  logic [IW:0] j;
  logic req_func;
  logic [LEN_W-1:0] req_size;
  logic [START_W-1:0] req_addr;
  entry_t cur;
  logic [1:0] res_status;
  logic [START_W-1:0] res_addr;
  logic pv_merge;

  logic we;
  logic [IW-1:0] waddr, raddr;
  entry_t wdata, rdata;
  logic [ENTRY_W-1:0] rbits;

  ffsa_ram #(.WIDTH(ENTRY_W), .DEPTH(MAX_SEGMENTS)) u_table (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata),
    .raddr(raddr), .rdata(rbits)
  );
  assign rdata = entry_t'(rbits);

  logic cfg_wr;
  logic [LEN_W-1:0] cfg_v;
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr == 2'd0);
  assign prdata = (paddr == 2'd0) ? {15'd0, pool_size} : 32'd0;

  always_comb begin
    cfg_v = pwdata[16:0];
    if (cfg_v == '0) begin
      cfg_v = LEN_W'(1);
    end
    if (cfg_v > CAP) begin
      cfg_v = CAP;
    end
  end

  assign busy = (state != S_IDLE);

  always_comb begin
    state_next = state;
    we = 1'b0;
    waddr = '0;
    wdata = '0;
    raddr = idx[IW-1:0];
    unique case (state)
      S_IDLE: begin
        if (start) begin
          state_next = S_SCAN_RD;
        end
      end
      S_INIT: begin
        we = 1'b1;
        wdata.start = '0;
        wdata.len = pool_size;
        wdata.is_free = 1'b1;
        state_next = S_IDLE;
      end
      S_SCAN_RD: begin
        if (idx >= (IW+1)'(seg_count)) begin
          state_next = S_DONE;
        end else begin
          state_next = S_SCAN_CHK;
        end
      end
      S_SCAN_CHK: begin
        state_next = S_SCAN_RD;
        if (req_func == FUNC_ALLOC) begin
          if (rdata.is_free && (req_size == '0 || rdata.len == req_size)) begin
            we = (req_size != '0);
            waddr = idx[IW-1:0];
            wdata = rdata;
            wdata.is_free = 1'b0;
            state_next = S_DONE;
          end else if (rdata.is_free && rdata.len > req_size) begin
            if (seg_count >= MAXC) begin
              state_next = S_DONE;
            end else begin
              we = 1'b1;
              waddr = idx[IW-1:0];
              wdata = rdata;
              wdata.len = req_size;
              wdata.is_free = 1'b0;
              state_next = S_SHUP_RD;
            end
          end
        end else if (rdata.start == req_addr) begin
          we = 1'b1;
          waddr = idx[IW-1:0];
          wdata = rdata;
          wdata.is_free = 1'b1;
          state_next = S_FREE_NX;
        end
      end
      S_SHUP_RD: begin
        raddr = IW'(j - 1'b1);
        if (j <= idx + 1'b1) begin
          state_next = S_SPLIT;
        end else begin
          state_next = S_SHUP_WR;
        end
      end
      S_SHUP_WR: begin
        we = 1'b1;
        waddr = j[IW-1:0];
        wdata = rdata;
        state_next = S_SHUP_RD;
      end
      S_SPLIT: begin
        we = 1'b1;
        waddr = IW'(idx + 1'b1);
        wdata.start = cur.start + req_size[START_W-1:0];
        wdata.len = cur.len - req_size;
        wdata.is_free = 1'b1;
        state_next = S_DONE;
      end
      S_FREE_NX: begin
        raddr = IW'(idx + 1'b1);
        if ((IW+1)'(idx + 1'b1) < (IW+1)'(seg_count)) begin
          state_next = S_FREE_NXCHK;
        end else begin
          state_next = S_FREE_PV;
        end
      end
      S_FREE_NXCHK: begin
        state_next = S_FREE_PV;
        if (rdata.is_free) begin
          we = 1'b1;
          waddr = idx[IW-1:0];
          wdata = cur;
          wdata.len = cur.len + rdata.len;
          wdata.is_free = 1'b1;
          state_next = S_SHDN_RD;
        end
      end
      S_FREE_PV: begin
        raddr = IW'(idx - 1'b1);
        if (idx != '0) begin
          state_next = S_FREE_PVCHK;
        end else begin
          state_next = S_DONE;
        end
      end
      S_FREE_PVCHK: begin
        state_next = S_DONE;
        if (rdata.is_free) begin
          we = 1'b1;
          waddr = IW'(idx - 1'b1);
          wdata = rdata;
          wdata.len = rdata.len + cur.len;
          state_next = S_SHDN_RD;
        end
      end
      S_SHDN_RD: begin
        raddr = IW'(j + 1'b1);
        if ((IW+1)'(j + 1'b1) >= (IW+1)'(seg_count)) begin
          state_next = pv_merge ? S_DONE : S_FREE_PV;
        end else begin
          state_next = S_SHDN_WR;
        end
      end
      S_SHDN_WR: begin
        we = 1'b1;
        waddr = j[IW-1:0];
        wdata = rdata;
        state_next = S_SHDN_RD;
      end
      S_DONE: begin
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
    if (cfg_wr) begin
      state_next = S_INIT;
    end
  end

  // After a merge with the predecessor the removal pass ends the transaction.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_INIT;
      pool_size <= CAP;
      seg_count <= CW'(1);
      done <= 1'b0;
      addr <= '0;
      status <= ST_OK;
      idx <= '0;
      j <= '0;
      pv_merge <= 1'b0;
    end else begin
      state <= state_next;
      done <= (state == S_DONE);
      if (cfg_wr) begin
        pool_size <= cfg_v;
      end
      unique case (state)
        S_INIT: begin
          seg_count <= CW'(1);
        end
        S_IDLE: begin
          if (start) begin
            req_func <= func;
            req_size <= alloc_size;
            req_addr <= free_addr;
            idx <= '0;
            pv_merge <= 1'b0;
            res_addr <= '0;
            res_status <= (func == FUNC_ALLOC) ? ST_NOFIT : ST_NOTFOUND;
          end
        end
        S_SCAN_CHK: begin
          cur <= rdata;
          if (state_next == S_SCAN_RD) begin
            idx <= idx + 1'b1;
          end else if (req_func == FUNC_ALLOC) begin
            if (state_next == S_DONE && seg_count >= MAXC &&
                rdata.len != req_size && req_size != '0) begin
              res_status <= ST_FULL;
            end else begin
              res_status <= ST_OK;
              res_addr <= rdata.start;
            end
            j <= (IW+1)'(seg_count);
          end else begin
            res_status <= ST_OK;
          end
        end
        S_SHUP_WR: begin
          j <= j - 1'b1;
        end
        S_SPLIT: begin
          seg_count <= seg_count + 1'b1;
        end
        S_FREE_NXCHK: begin
          if (rdata.is_free) begin
            cur.len <= cur.len + rdata.len;
            j <= idx + 1'b1;
          end
        end
        S_FREE_PVCHK: begin
          if (rdata.is_free) begin
            j <= idx;
            pv_merge <= 1'b1;
          end
        end
        S_SHDN_RD: begin
          if ((IW+1)'(j + 1'b1) >= (IW+1)'(seg_count)) begin
            seg_count <= seg_count - 1'b1;
          end
        end
        S_SHDN_WR: begin
          j <= j + 1'b1;
        end
        S_DONE: begin
          addr <= res_addr;
          status <= res_status;
        end
        default: begin
        end
      endcase
    end
  end

  assert property (@(posedge clk) disable iff (rst) done |-> $past(state) == S_DONE)
    else $error("result without completion");
  assert property (@(posedge clk) disable iff (rst) seg_count <= MAXC && seg_count != '0)
    else $error("segment count out of range");
  assert property (@(posedge clk) disable iff (rst) (start && !busy && !cfg_wr) |=> busy)
    else $error("request not taken");
endmodule

### sim/tb_top.sv
// Self-checking testbench for the first-fit segment allocator.
// Drives allocate and free requests and pool_size writes, predicts each result
// from a segment table model, and checks every result. Depends on ffsa_pkg and first_fit_segment_allocator.
class seg_scoreboard;
  int unsigned pool_bytes;
  bit [15:0] seg_base[16];
  bit [16:0] seg_bytes[16];
  bit        seg_open[16];
  int        seg_total;
  bit [15:0] want_addr[$];
  bit [1:0]  want_status[$];
  int        mismatches;
  int        orphans;

  function void rebuild(int unsigned size);
    pool_bytes = size;
    for (int i = 0; i < 16; i++) begin
      seg_base[i] = '0;
      seg_bytes[i] = '0;
      seg_open[i] = 1'b0;
    end
    seg_bytes[0] = 17'(size);
    seg_open[0] = 1'b1;
    seg_total = 1;
  endfunction

  function void write_pool(bit [31:0] value);
    int unsigned v;
    v = {15'd0, value[16:0]};
    if (v == 0) v = 1;
    if (v > 65536) v = 65536;
    rebuild(v);
  endfunction

  function void drop_entry(int k);
    for (int i = k; i + 1 < seg_total; i++) begin
      seg_base[i] = seg_base[i + 1];
      seg_bytes[i] = seg_bytes[i + 1];
      seg_open[i] = seg_open[i + 1];
    end
    seg_total--;
    seg_base[seg_total] = '0;
    seg_bytes[seg_total] = '0;
    seg_open[seg_total] = 1'b0;
  endfunction

  function void note_request(bit fn, bit [16:0] size, bit [15:0] where);
    bit [15:0] a;
    bit [1:0]  s;
    bit        hit;
    a = '0;
    s = ffsa_pkg::ST_OK;
    hit = 1'b0;
    if (fn == ffsa_pkg::FUNC_ALLOC) begin
      s = ffsa_pkg::ST_NOFIT;
      for (int i = 0; i < seg_total && !hit; i++) begin
        if (seg_open[i] && (size == 0 || seg_bytes[i] >= size)) begin
          hit = 1'b1;
          if (size == 0) begin
            a = seg_base[i];
            s = ffsa_pkg::ST_OK;
          end else if (seg_bytes[i] > size && seg_total >= 16) begin
            s = ffsa_pkg::ST_FULL;
          end else begin
            if (seg_bytes[i] > size) begin
              for (int j = seg_total; j > i + 1; j--) begin
                seg_base[j] = seg_base[j - 1];
                seg_bytes[j] = seg_bytes[j - 1];
                seg_open[j] = seg_open[j - 1];
              end
              seg_base[i + 1] = seg_base[i] + size[15:0];
              seg_bytes[i + 1] = seg_bytes[i] - size;
              seg_open[i + 1] = 1'b1;
              seg_total++;
              seg_bytes[i] = size;
            end
            seg_open[i] = 1'b0;
            a = seg_base[i];
            s = ffsa_pkg::ST_OK;
          end
        end
      end
    end else begin
      s = ffsa_pkg::ST_NOTFOUND;
      for (int i = 0; i < seg_total && !hit; i++) begin
        if (seg_base[i] == where) begin
          hit = 1'b1;
          s = ffsa_pkg::ST_OK;
          seg_open[i] = 1'b1;
          if (i + 1 < seg_total && seg_open[i + 1]) begin
            seg_bytes[i] += seg_bytes[i + 1];
            drop_entry(i + 1);
          end
          if (i > 0 && seg_open[i - 1]) begin
            seg_bytes[i - 1] += seg_bytes[i];
            drop_entry(i);
          end
        end
      end
    end
    want_addr.push_back(a);
    want_status.push_back(s);
  endfunction

  function void check_result(bit [15:0] a, bit [1:0] s);
    bit [15:0] ea;
    bit [1:0]  es;
    if (want_addr.size() == 0) begin
      orphans++;
      if (mismatches + orphans <= 10) $display("Unexpected result addr=%0d status=%0d", a, s);
      return;
    end
    ea = want_addr.pop_front();
    es = want_status.pop_front();
    if (ea != a || es != s) begin
      mismatches++;
      if (mismatches + orphans <= 10)
        $display("Mismatch: expected addr=%0d status=%0d, got addr=%0d status=%0d",
                 ea, es, a, s);
    end
  endfunction
endclass

module tb_top;
  import ffsa_pkg::*;

  logic        clk;
  logic        rst;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [1:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;
  logic        start;
  logic        busy;
  logic        func;
  logic [16:0] alloc_size;
  logic [15:0] free_addr;
  logic        done;
  logic [15:0] addr;
  logic [1:0]  status;

  seg_scoreboard table_model;
  bit [15:0] issued[$];
  int        readback_errors;

  first_fit_segment_allocator DUT (.*);

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #50000000;
    $display("FAIL");
    $finish;
  end

  always @(posedge clk) begin
    if (!rst && done) table_model.check_result(addr, status);
  end

  task automatic write_pool_size(bit [31:0] value);
    @(negedge clk);
    psel = 1'b1;
    pwrite = 1'b1;
    paddr = '0;
    pwdata = value;
    @(negedge clk);
    penable = 1'b1;
    @(negedge clk);
    penable = 1'b0;
    pwrite = 1'b0;
    table_model.write_pool(value);
    @(negedge clk);
    penable = 1'b1;
    @(negedge clk);
    if (prdata[16:0] != table_model.pool_bytes[16:0]) readback_errors++;
    psel = 1'b0;
    penable = 1'b0;
    issued.delete();
  endtask

  task automatic send_request(bit fn, bit [16:0] size, bit [15:0] where);
    int gap;
    gap = $urandom_range(0, 4);
    repeat (gap) @(negedge clk);
    func = fn;
    alloc_size = size;
    free_addr = where;
    start = 1'b1;
    @(posedge clk);
    while (busy) @(posedge clk);
    table_model.note_request(fn, size, where);
    @(negedge clk);
    start = 1'b0;
  endtask

  task automatic wait_drained();
    int guard;
    guard = 0;
    while (table_model.want_addr.size() != 0 && guard < 2000) begin
      @(posedge clk);
      guard++;
    end
    repeat (120) @(posedge clk);
  endtask

  task automatic random_phase(int count, int unsigned pool);
    bit [16:0] size;
    int pick;
    for (int n = 0; n < count; n++) begin
      pick = $urandom_range(0, 99);
      if (pick < 45) begin
        case ($urandom_range(0, 3))
          0: size = 17'($urandom_range(0, 16));
          1: size = 17'($urandom_range(1, pool / 8 + 1));
          2: size = 17'($urandom_range(0, pool));
          default: size = 17'($urandom_range(0, 17'h1FFFF));
        endcase
        send_request(FUNC_ALLOC, size, 16'($urandom));
        if (table_model.want_status[$] == ST_OK && size != 0)
          issued.push_back(table_model.want_addr[$]);
      end else if (pick < 85 && issued.size() != 0) begin
        pick = $urandom_range(0, issued.size() - 1);
        send_request(FUNC_FREE, 17'($urandom), issued[pick]);
        issued.delete(pick);
      end else begin
        send_request(pick[0] ? FUNC_FREE : FUNC_ALLOC, 17'($urandom), 16'($urandom));
      end
    end
  endtask

  initial begin
    int unsigned pool;
    table_model = new();
    table_model.rebuild(65536);
    readback_errors = 0;
    rst = 1'b1;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    start = 1'b0;
    func = FUNC_ALLOC;
    alloc_size = '0;
    free_addr = '0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    send_request(FUNC_ALLOC, 17'd0, 16'hFFFF);
    send_request(FUNC_ALLOC, 17'h10000, 16'd0);
    send_request(FUNC_FREE, 17'h1FFFF, 16'd0);
    send_request(FUNC_FREE, 17'd0, 16'h1234);
    send_request(FUNC_ALLOC, 17'h10001, 16'd0);
    send_request(FUNC_ALLOC, 17'h1FFFF, 16'd0);
    send_request(FUNC_ALLOC, 17'd0, 16'd0);
    send_request(FUNC_FREE, 17'd0, 16'd0);
    wait_drained();
    write_pool_size(32'd0);
    send_request(FUNC_ALLOC, 17'd1, 16'd0);
    send_request(FUNC_ALLOC, 17'd0, 16'd0);
    send_request(FUNC_FREE, 17'd0, 16'd0);
    wait_drained();
    write_pool_size(32'hFFFF_FFFF);
    for (int i = 0; i < 16; i++) send_request(FUNC_ALLOC, 17'd1, 16'd0);
    send_request(FUNC_FREE, 17'd0, 16'd5);
    send_request(FUNC_FREE, 17'd0, 16'd5);
    send_request(FUNC_FREE, 17'd0, 16'd4);
    send_request(FUNC_FREE, 17'd0, 16'd6);
    wait_drained();

    for (int phase = 0; phase < 6; phase++) begin
      case (phase)
        0: pool = 65536;
        1: pool = 64;
        2: pool = $urandom_range(1, 65536);
        3: pool = 1;
        4: pool = 1024;
        default: pool = $urandom_range(16, 4096);
      endcase
      write_pool_size(pool);
      random_phase(170, pool);
      wait_drained();
    end

    if (table_model.mismatches == 0 && table_model.orphans == 0 &&
        table_model.want_addr.size() == 0 && readback_errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end
endmodule
